// ----- rtl/core/spm_pkg.sv -----
`default_nettype none
package spm_pkg;

    localparam int PAGE_BYTES       = 4096;
    localparam int HEADER_BYTES     = 8;
    localparam int SLOT_ENTRY_BYTES = 4;
    localparam int MAX_SLOTS        = 1024;
    localparam int ADDR_W           = 12;
    localparam int SLOT_W           = 10;

    // item kinds as they arrive
    localparam logic [2:0] KIND_INS_START = 3'd0;
    localparam logic [2:0] KIND_INS_BYTE  = 3'd1;
    localparam logic [2:0] KIND_READ      = 3'd2;
    localparam logic [2:0] KIND_REMOVE    = 3'd3;
    localparam logic [2:0] KIND_COMPACT   = 3'd4;
    localparam logic [2:0] KIND_PEEK      = 3'd5;

    // classified operations
    localparam logic [2:0] OP_INS_START = 3'd0;
    localparam logic [2:0] OP_INS_BYTE  = 3'd1;
    localparam logic [2:0] OP_READ      = 3'd2;
    localparam logic [2:0] OP_REMOVE    = 3'd3;
    localparam logic [2:0] OP_COMPACT   = 3'd4;
    localparam logic [2:0] OP_PEEK      = 3'd5;
    localparam logic [2:0] OP_BAD       = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_SEQ      = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] record_length;
        logic [7:0]  data_byte;
        logic [9:0]  slot_number;
        logic [11:0] byte_address;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  slot_id;
        logic [11:0] record_offset;
        logic [11:0] length_out;
        logic [7:0]  byte_out;
        logic [12:0] free_bytes;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] record_length;
        logic [7:0]  data_byte;
        logic [9:0]  slot_number;
        logic [11:0] byte_address;
    } cmd_t;

    function automatic logic [12:0] free_calc(input logic [10:0] slots,
                                              input logic [12:0] dend);
        logic [16:0] dir;
        logic [16:0] ds;
        logic [12:0] r;
        dir = 17'(slots) * 17'(SLOT_ENTRY_BYTES);
        ds  = 17'(PAGE_BYTES) - dir;
        if (dir > 17'(PAGE_BYTES) || ds <= 17'(dend))
            r = 13'd0;
        else
            r = 13'(ds - 17'(dend));
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/spm_ram.sv -----
`default_nettype none
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/spm_front.sv -----
`default_nettype none
module spm_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire spm_pkg::in_item_t  item,
    output logic                    full,
    output logic                    cmd_valid,
    output spm_pkg::cmd_t           cmd,
    input  wire logic               cmd_take
);

    spm_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    spm_pkg::cmd_t classified;
    logic          do_push;

    // decode kind into an operation
    always_comb
    begin
        classified.record_length = item.record_length;
        classified.data_byte     = item.data_byte;
        classified.slot_number   = item.slot_number;
        classified.byte_address  = item.byte_address;
        case (item.kind)
            spm_pkg::KIND_INS_START: classified.op = spm_pkg::OP_INS_START;
            spm_pkg::KIND_INS_BYTE:  classified.op = spm_pkg::OP_INS_BYTE;
            spm_pkg::KIND_READ:      classified.op = spm_pkg::OP_READ;
            spm_pkg::KIND_REMOVE:    classified.op = spm_pkg::OP_REMOVE;
            spm_pkg::KIND_COMPACT:   classified.op = spm_pkg::OP_COMPACT;
            spm_pkg::KIND_PEEK:      classified.op = spm_pkg::OP_PEEK;
            default:                 classified.op = spm_pkg::OP_BAD;
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign do_push   = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= classified;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (cmd_take)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(cmd_take);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/spm_back.sv -----
`default_nettype none
module spm_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire spm_pkg::cmd_t      cmd,
    input  wire logic               out_space,
    output logic                    cmd_take,
    output logic                    res_valid,
    output spm_pkg::out_item_t      res
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH_RD  = 4'd1;
    localparam logic [3:0] S_SRCH_CHK = 4'd2;
    localparam logic [3:0] S_DIR_CHK  = 4'd3;
    localparam logic [3:0] S_PEEK     = 4'd4;
    localparam logic [3:0] S_CP_DRD   = 4'd5;
    localparam logic [3:0] S_CP_DCHK  = 4'd6;
    localparam logic [3:0] S_CP_RD    = 4'd7;
    localparam logic [3:0] S_CP_WR    = 4'd8;

    logic [3:0]    state_reg,      state_next;
    spm_pkg::cmd_t cmd_reg,        cmd_next;
    logic [12:0]   data_end_reg,   data_end_next;
    logic [10:0]   slots_used_reg, slots_used_next;
    logic [10:0]   tomb_reg,       tomb_next;
    logic [12:0]   pend_rem_reg,   pend_rem_next;
    logic [11:0]   pend_start_reg, pend_start_next;
    logic          busy_reg,       busy_next;
    logic          bank_reg,       bank_next;
    logic [10:0]   idx_reg,        idx_next;
    logic [10:0]   dense_reg,      dense_next;
    logic [12:0]   fill_reg,       fill_next;
    logic [11:0]   cp_off_reg,     cp_off_next;
    logic [11:0]   cp_len_reg,     cp_len_next;
    logic [11:0]   k_reg,          k_next;
    logic [11:0]   asg_off_reg,    asg_off_next;
    logic [11:0]   asg_len_reg,    asg_len_next;

    logic          dir_we, dir_re;
    logic [9:0]    dir_waddr, dir_raddr;
    logic [23:0]   dir_wdata, dir_rdata;
    logic          pg_we_cur, pg_we_oth, pg_re;
    logic [11:0]   pg_waddr, pg_raddr;
    logic [7:0]    pg_wdata;
    logic [7:0]    rd0, rd1, pg_rdata;

    spm_ram #(.WIDTH(24), .DEPTH(spm_pkg::MAX_SLOTS)) u_dir (
        .clk(clk), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
        .re(dir_re), .raddr(dir_raddr), .rdata(dir_rdata)
    );

    // two page banks, the idle one serves as scratch during compaction
    spm_ram #(.WIDTH(8), .DEPTH(spm_pkg::PAGE_BYTES)) u_bank0 (
        .clk(clk),
        .we((pg_we_cur && !bank_reg) || (pg_we_oth && bank_reg)),
        .waddr(pg_waddr), .wdata(pg_wdata),
        .re(pg_re), .raddr(pg_raddr), .rdata(rd0)
    );

    spm_ram #(.WIDTH(8), .DEPTH(spm_pkg::PAGE_BYTES)) u_bank1 (
        .clk(clk),
        .we((pg_we_cur && bank_reg) || (pg_we_oth && !bank_reg)),
        .waddr(pg_waddr), .wdata(pg_wdata),
        .re(pg_re), .raddr(pg_raddr), .rdata(rd1)
    );

    assign pg_rdata = bank_reg ? rd1 : rd0;

    always_comb
    begin
        logic [12:0] need;
        logic        fail;
        logic [12:0] dend_inc;
        logic [12:0] rem_dec;
        logic [12:0] src;
        logic [12:0] dst;
        logic        new_ok;

        state_next      = state_reg;
        cmd_next        = cmd_reg;
        data_end_next   = data_end_reg;
        slots_used_next = slots_used_reg;
        tomb_next       = tomb_reg;
        pend_rem_next   = pend_rem_reg;
        pend_start_next = pend_start_reg;
        busy_next       = busy_reg;
        bank_next       = bank_reg;
        idx_next        = idx_reg;
        dense_next      = dense_reg;
        fill_next       = fill_reg;
        cp_off_next     = cp_off_reg;
        cp_len_next     = cp_len_reg;
        k_next          = k_reg;
        asg_off_next    = asg_off_reg;
        asg_len_next    = asg_len_reg;

        cmd_take  = 1'b0;
        res_valid = 1'b0;
        res       = '0;
        dir_we    = 1'b0;
        dir_re    = 1'b0;
        dir_waddr = '0;
        dir_raddr = '0;
        dir_wdata = '0;
        pg_we_cur = 1'b0;
        pg_we_oth = 1'b0;
        pg_re     = 1'b0;
        pg_waddr  = '0;
        pg_raddr  = '0;
        pg_wdata  = '0;

        need     = 13'(cmd.record_length) + 13'(spm_pkg::SLOT_ENTRY_BYTES);
        fail     = (spm_pkg::free_calc(slots_used_reg, data_end_reg) < need) ||
                   (tomb_reg == 11'd0 && slots_used_reg >= 11'(spm_pkg::MAX_SLOTS));
        dend_inc = data_end_reg + 13'd1;
        rem_dec  = pend_rem_reg - 13'd1;
        src      = 13'(cp_off_reg) + 13'(k_reg);
        dst      = fill_reg + 13'(k_reg);
        new_ok   = slots_used_reg < 11'(spm_pkg::MAX_SLOTS);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_space)
                begin
                    cmd_take = 1'b1;
                    cmd_next = cmd;
                    case (cmd.op)
                        spm_pkg::OP_INS_START:
                        begin
                            if (busy_reg)
                            begin
                                res_valid  = 1'b1;
                                res.status = spm_pkg::ST_SEQ;
                            end
                            else if (fail)
                            begin
                                res_valid  = 1'b1;
                                res.status = spm_pkg::ST_NO_SPACE;
                            end
                            else if (cmd.record_length == 12'd0)
                            begin
                                asg_off_next = data_end_reg[11:0];
                                asg_len_next = 12'd0;
                                if (tomb_reg != 11'd0)
                                begin
                                    idx_next   = 11'd0;
                                    state_next = S_SRCH_RD;
                                end
                                else
                                begin
                                    res_valid   = 1'b1;
                                    res.slot_id = slots_used_reg[9:0];
                                    if (new_ok)
                                    begin
                                        dir_we          = 1'b1;
                                        dir_waddr       = slots_used_reg[9:0];
                                        dir_wdata       = {data_end_reg[11:0], 12'd0};
                                        slots_used_next = slots_used_reg + 11'd1;
                                    end
                                end
                            end
                            else
                            begin
                                res_valid       = 1'b1;
                                pend_start_next = data_end_reg[11:0];
                                pend_rem_next   = 13'(cmd.record_length);
                                busy_next       = 1'b1;
                            end
                        end
                        spm_pkg::OP_INS_BYTE:
                        begin
                            if (!busy_reg)
                            begin
                                res_valid  = 1'b1;
                                res.status = spm_pkg::ST_SEQ;
                            end
                            else
                            begin
                                if (data_end_reg < 13'(spm_pkg::PAGE_BYTES))
                                begin
                                    pg_we_cur = 1'b1;
                                    pg_waddr  = data_end_reg[11:0];
                                    pg_wdata  = cmd.data_byte;
                                end
                                data_end_next = dend_inc;
                                pend_rem_next = rem_dec;
                                if (rem_dec == 13'd0)
                                begin
                                    busy_next    = 1'b0;
                                    asg_off_next = pend_start_reg;
                                    asg_len_next = 12'(dend_inc - 13'(pend_start_reg));
                                    if (tomb_reg != 11'd0)
                                    begin
                                        idx_next   = 11'd0;
                                        state_next = S_SRCH_RD;
                                    end
                                    else
                                    begin
                                        res_valid   = 1'b1;
                                        res.slot_id = slots_used_reg[9:0];
                                        if (new_ok)
                                        begin
                                            dir_we          = 1'b1;
                                            dir_waddr       = slots_used_reg[9:0];
                                            dir_wdata       = {pend_start_reg,
                                                12'(dend_inc - 13'(pend_start_reg))};
                                            slots_used_next = slots_used_reg + 11'd1;
                                        end
                                    end
                                end
                            end
                        end
                        spm_pkg::OP_READ, spm_pkg::OP_REMOVE:
                        begin
                            if (11'(cmd.slot_number) >= slots_used_reg)
                            begin
                                res_valid  = 1'b1;
                                res.status = spm_pkg::ST_RANGE;
                            end
                            else
                            begin
                                dir_re     = 1'b1;
                                dir_raddr  = cmd.slot_number;
                                state_next = S_DIR_CHK;
                            end
                        end
                        spm_pkg::OP_COMPACT:
                        begin
                            if (busy_reg)
                            begin
                                res_valid  = 1'b1;
                                res.status = spm_pkg::ST_SEQ;
                            end
                            else
                            begin
                                idx_next   = 11'd0;
                                dense_next = 11'd0;
                                fill_next  = 13'(spm_pkg::HEADER_BYTES);
                                state_next = S_CP_DRD;
                            end
                        end
                        spm_pkg::OP_PEEK:
                        begin
                            // bytes outside the record area are always zero
                            if (cmd.byte_address >= 12'(spm_pkg::HEADER_BYTES) &&
                                13'(cmd.byte_address) < data_end_reg)
                            begin
                                pg_re      = 1'b1;
                                pg_raddr   = cmd.byte_address;
                                state_next = S_PEEK;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_valid  = 1'b1;
                            res.status = spm_pkg::ST_SEQ;
                        end
                    endcase
                end
            end
            S_SRCH_RD:
            begin
                if (idx_reg < slots_used_reg)
                begin
                    dir_re     = 1'b1;
                    dir_raddr  = idx_reg[9:0];
                    state_next = S_SRCH_CHK;
                end
                else
                begin
                    res_valid   = 1'b1;
                    res.slot_id = slots_used_reg[9:0];
                    if (new_ok)
                    begin
                        dir_we          = 1'b1;
                        dir_waddr       = slots_used_reg[9:0];
                        dir_wdata       = {asg_off_reg, asg_len_reg};
                        slots_used_next = slots_used_reg + 11'd1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SRCH_CHK:
            begin
                if (dir_rdata[23:12] == 12'd0)
                begin
                    dir_we      = 1'b1;
                    dir_waddr   = idx_reg[9:0];
                    dir_wdata   = {asg_off_reg, asg_len_reg};
                    tomb_next   = tomb_reg - 11'd1;
                    res_valid   = 1'b1;
                    res.slot_id = idx_reg[9:0];
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 11'd1;
                    state_next = S_SRCH_RD;
                end
            end
            S_DIR_CHK:
            begin
                res_valid  = 1'b1;
                state_next = S_IDLE;
                if (dir_rdata[23:12] == 12'd0)
                begin
                    res.status = spm_pkg::ST_REMOVED;
                end
                else if (cmd_reg.op == spm_pkg::OP_READ)
                begin
                    res.record_offset = dir_rdata[23:12];
                    res.length_out    = dir_rdata[11:0];
                end
                else
                begin
                    dir_we    = 1'b1;
                    dir_waddr = cmd_reg.slot_number;
                    dir_wdata = '0;
                    tomb_next = tomb_reg + 11'd1;
                end
            end
            S_PEEK:
            begin
                res_valid    = 1'b1;
                res.byte_out = pg_rdata;
                state_next   = S_IDLE;
            end
            S_CP_DRD:
            begin
                if (idx_reg < slots_used_reg)
                begin
                    dir_re     = 1'b1;
                    dir_raddr  = idx_reg[9:0];
                    state_next = S_CP_DCHK;
                end
                else
                begin
                    bank_next       = !bank_reg;
                    data_end_next   = fill_reg;
                    slots_used_next = dense_reg;
                    tomb_next       = 11'd0;
                    res_valid       = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_CP_DCHK:
            begin
                if (dir_rdata[23:12] == 12'd0)
                begin
                    idx_next   = idx_reg + 11'd1;
                    state_next = S_CP_DRD;
                end
                else
                begin
                    cp_off_next = dir_rdata[23:12];
                    cp_len_next = dir_rdata[11:0];
                    k_next      = 12'd0;
                    state_next  = S_CP_RD;
                end
            end
            S_CP_RD:
            begin
                if (k_reg == cp_len_reg)
                begin
                    dir_we     = 1'b1;
                    dir_waddr  = dense_reg[9:0];
                    dir_wdata  = {fill_reg[11:0], cp_len_reg};
                    dense_next = dense_reg + 11'd1;
                    fill_next  = fill_reg + 13'(cp_len_reg);
                    idx_next   = idx_reg + 11'd1;
                    state_next = S_CP_DRD;
                end
                else
                begin
                    pg_re      = 1'b1;
                    pg_raddr   = src[11:0];
                    state_next = S_CP_WR;
                end
            end
            S_CP_WR:
            begin
                if (src < 13'(spm_pkg::PAGE_BYTES) && dst < 13'(spm_pkg::PAGE_BYTES))
                begin
                    pg_we_oth = 1'b1;
                    pg_waddr  = dst[11:0];
                    pg_wdata  = pg_rdata;
                end
                k_next     = k_reg + 12'd1;
                state_next = S_CP_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.free_bytes = spm_pkg::free_calc(slots_used_next, data_end_next);
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        dense_reg   <= dense_next;
        fill_reg    <= fill_next;
        cp_off_reg  <= cp_off_next;
        cp_len_reg  <= cp_len_next;
        k_reg       <= k_next;
        asg_off_reg <= asg_off_next;
        asg_len_reg <= asg_len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            data_end_reg   <= 13'(spm_pkg::HEADER_BYTES);
            slots_used_reg <= 11'd0;
            tomb_reg       <= 11'd0;
            pend_rem_reg   <= 13'd0;
            pend_start_reg <= 12'd0;
            busy_reg       <= 1'b0;
            bank_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            data_end_reg   <= data_end_next;
            slots_used_reg <= slots_used_next;
            tomb_reg       <= tomb_next;
            pend_rem_reg   <= pend_rem_next;
            pend_start_reg <= pend_start_next;
            busy_reg       <= busy_next;
            bank_reg       <= bank_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/slotted_page_manager_core.sv -----
`default_nettype none
// channel   | direction | handshake         | beat
// ----------+-----------+-------------------+--------------------------
// item      | in        | push / full       | spm_pkg::in_item_t
// result    | out       | pop / empty       | spm_pkg::out_item_t
//
// insert bytes, reads of an out-of-range slot and sequence errors finish in
// the idle state; slot reads, removes and page byte reads in the record area
// wait on a directory or page memory read; a tombstone-reusing insert walks
// the directory slot by slot; compact walks each slot and copies each live
// record byte with a read then a write via the single page memory read port.
// reset is asynchronous; the page needs no clearing pass after reset.
// a two-beat queue on each side lets the front keep accepting while the back
// works or while results wait to be popped.
module slotted_page_manager_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire spm_pkg::in_item_t   item,
    output logic                     full,
    output logic                     empty,
    input  wire logic                pop,
    output spm_pkg::out_item_t       result
);

    logic               cmd_valid;
    spm_pkg::cmd_t      cmd;
    logic               cmd_take;
    logic               res_valid;
    spm_pkg::out_item_t res;

    // result queue
    spm_pkg::out_item_t rq_reg [2];
    logic               rq_wr_reg;
    logic               rq_rd_reg;
    logic [1:0]         rq_count_reg;
    logic               rq_pop;

    // accept and classify
    spm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .push(push), .item(item), .full(full),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    // execute against page and directory
    spm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd(cmd),
        .out_space(rq_count_reg != 2'd2),
        .cmd_take(cmd_take),
        .res_valid(res_valid), .res(res)
    );

    assign empty  = (rq_count_reg == 2'd0);
    assign rq_pop = pop && !empty;
    assign result = rq_reg[rq_rd_reg];

    always_ff @(posedge clk)
    begin
        if (res_valid)
            rq_reg[rq_wr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg    <= 1'b0;
            rq_rd_reg    <= 1'b0;
            rq_count_reg <= 2'd0;
        end
        else
        begin
            if (res_valid)
                rq_wr_reg <= !rq_wr_reg;
            if (rq_pop)
                rq_rd_reg <= !rq_rd_reg;
            rq_count_reg <= rq_count_reg + 2'(res_valid) - 2'(rq_pop);
        end
    end

    // the back end never starts an item without room for its result
    a_take_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> rq_count_reg != 2'd2)
        else $error("item taken with result queue full");

    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> rq_count_reg != 2'd2)
        else $error("result written into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rq_count_reg != 2'd3)
        else $error("result queue count out of range");

    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("back end took from empty item queue");

endmodule
`default_nettype wire
